/* src/round_integer_to_multiple_top_macros.svh */
// assertion macros for the round-to-multiple block
`ifndef ROUND_INTEGER_TO_MULTIPLE_TOP_MACROS_SVH
`define ROUND_INTEGER_TO_MULTIPLE_TOP_MACROS_SVH

// clocked check, idle during reset
`define RIM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check, also active during reset
`define RIM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* src/rim_pkg.sv */
// shared types and codes of the round-to-multiple block
`default_nettype none
package rim_pkg;
   localparam int DW = 64;

   localparam logic [2:0] MODE_HALF_AWAY = 3'd0;
   localparam logic [2:0] MODE_HALF_EVEN = 3'd1;
   localparam logic [2:0] MODE_HALF_DOWN = 3'd2;
   localparam logic [2:0] MODE_HALF_CEIL = 3'd3;
   localparam logic [2:0] MODE_TRUNC     = 3'd4;
   localparam logic [2:0] MODE_FLOOR     = 3'd5;
   localparam logic [2:0] MODE_CEIL      = 3'd6;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZDIV = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   typedef struct packed {
      logic [DW-1:0] v;
      logic [DW-1:0] n;
      logic [DW-1:0] nsh;
      logic [DW-1:0] sc;
      logic [DW-1:0] p;
      logic          neg;
      logic          zdiv;
      logic          q;
   } stage_type;
endpackage
`default_nettype wire

/* src/rim_div_stage.sv */
// one restoring step of the pipelined remainder unit
`default_nettype none
module rim_div_stage
   import rim_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      en,
   input  wire logic      valid_in,
   input  wire stage_type data_in,
   output logic           valid_ff,
   output stage_type      data_ff
);
   logic [DW-1:0] trial;
   logic          ge;
   stage_type     data_nx;

   always_comb begin
      trial = {data_in.p[DW-2:0], data_in.nsh[DW-1]};
      ge = trial >= data_in.sc;
      data_nx = data_in;
      data_nx.p = ge ? (trial - data_in.sc) : trial;
      data_nx.q = ge;
      data_nx.nsh = {data_in.nsh[DW-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_nx;
      end
   end
endmodule
`default_nettype wire

/* src/round_integer_to_multiple_top.sv */
// top level of the round-to-multiple block
// Rounds a signed value to a multiple of |step_size| (or of one when use_step
// is 0) under the mode in the csr register. Fully pipelined: one item can be
// taken every clock; its stages are one input register, DW
// restoring remainder steps one quotient bit each, one register that forms
// the remainder gap and the up/down candidates, and the two-entry output
// queue. The whole pipeline moves together and halts only while the output
// queue holds two items that the consumer has not taken.
`default_nettype none
module round_integer_to_multiple_top
   import rim_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,  // value_in[63:0], step_size[127:64]
   input  wire logic [0:0]   req_tuser,  // use_step[0]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [63:0]       rsp_tdata,  // rounded[63:0]
   output logic [1:0]        rsp_tuser,  // status[1:0]
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_data    // rounding_mode[2:0]
);
   `include "round_integer_to_multiple_top_macros.svh"

   typedef struct packed {
      logic [63:0] rounded;
      logic [1:0]  status;
   } out_type;

   // rounding mode register
   logic [2:0] mode_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_HALF_AWAY;
      end else if (csr_valid) begin
         mode_ff <= csr_data;
      end
   end

   // output queue state, pipeline advances while it has room
   logic [1:0] count_ff;
   logic       en;
   assign en = count_ff != 2'd2;
   assign req_tready = en;

   // input stage: reduce to DW bits, take magnitudes
   logic [DW-1:0] v_in, stp_in, mag_v, mag_s;
   logic          use_in, zdiv_in;
   stage_type     s0_in;
   always_comb begin
      v_in = req_tdata[DW-1:0];
      stp_in = req_tdata[64+DW-1:64];
      use_in = req_tuser[0];
      mag_v = v_in[DW-1] ? (~v_in + 1'b1) : v_in;
      mag_s = stp_in[DW-1] ? (~stp_in + 1'b1) : stp_in;
      zdiv_in = use_in && (stp_in == '0);
      s0_in.v = v_in;
      s0_in.n = mag_v;
      s0_in.nsh = mag_v;
      // a missing or zero step divides by one so the pipe holds sane data
      s0_in.sc = (use_in && !zdiv_in) ? mag_s : DW'(1);
      s0_in.p = '0;
      s0_in.neg = v_in[DW-1];
      s0_in.zdiv = zdiv_in;
      s0_in.q = 1'b0;
   end

   stage_type stg_data [DW+1];
   logic      stg_valid [DW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid[0] <= 1'b0;
      end else if (en) begin
         stg_valid[0] <= req_tvalid;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         stg_data[0] <= s0_in;
      end
   end

   // remainder pipeline, one quotient bit per stage, msb first
   for (genvar i = 0; i < DW; i++) begin : g_div
      rim_div_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .valid_in (stg_valid[i]),
         .data_in  (stg_data[i]),
         .valid_ff (stg_valid[i+1]),
         .data_ff  (stg_data[i+1])
      );
   end

   // candidate stage: gap, round-up and round-down magnitudes, tie compare
   logic          a_valid_ff;
   logic [DW-1:0] a_v_ff, a_dn_ff;
   logic [DW:0]   a_up_ff;
   logic          a_neg_ff, a_zdiv_ff, a_q_ff, a_exact_ff, a_lt_ff, a_eq_ff;
   stage_type     dv;
   assign dv = stg_data[DW];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= stg_valid[DW];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         a_v_ff <= dv.v;
         a_neg_ff <= dv.neg;
         a_zdiv_ff <= dv.zdiv;
         a_q_ff <= dv.q;
         a_exact_ff <= dv.p == '0;
         a_dn_ff <= dv.n - dv.p;
         a_up_ff <= {1'b0, dv.n} + {1'b0, dv.sc - dv.p};
         // r < s/2 and r == s/2, written as 2r against the step
         a_lt_ff <= {dv.p, 1'b0} < {1'b0, dv.sc};
         a_eq_ff <= {dv.p, 1'b0} == {1'b0, dv.sc};
      end
   end

   // decision: pick direction, check range, apply sign
   logic        go_up, ovf;
   logic [DW:0] half;
   logic [DW-1:0] mag, res;
   out_type     a_out;
   always_comb begin
      half = (DW+1)'(1) << (DW-1);
      case (mode_ff)
         MODE_TRUNC:     go_up = 1'b0;
         MODE_FLOOR:     go_up = a_neg_ff;
         MODE_CEIL:      go_up = !a_neg_ff;
         MODE_HALF_EVEN: go_up = a_lt_ff ? 1'b0 : (a_eq_ff ? a_q_ff : 1'b1);
         MODE_HALF_DOWN: go_up = !(a_lt_ff || a_eq_ff);
         MODE_HALF_CEIL: go_up = a_lt_ff ? 1'b0 : (a_eq_ff ? !a_neg_ff : 1'b1);
         default:        go_up = !a_lt_ff;
      endcase
      // a negative result may reach -2^(DW-1), a positive one may not
      ovf = go_up && (a_neg_ff ? (a_up_ff > half) : (a_up_ff >= half));
      mag = go_up ? a_up_ff[DW-1:0] : a_dn_ff;
      res = a_neg_ff ? (~mag + 1'b1) : mag;
      if (a_zdiv_ff) begin
         a_out.rounded = '0;
         a_out.status = ST_ZDIV;
      end else if (a_exact_ff) begin
         a_out.rounded = 64'($signed(a_v_ff));
         a_out.status = ST_OK;
      end else if (ovf) begin
         a_out.rounded = '0;
         a_out.status = ST_OVF;
      end else begin
         a_out.rounded = 64'($signed(res));
         a_out.status = ST_OK;
      end
   end

   // two-entry output queue, parts the pipeline from the consumer
   out_type q_mem [2];
   logic    wr_ptr_ff, rd_ptr_ff;
   logic    push, pop;
   assign push = en && a_valid_ff;
   assign pop = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= a_out;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   out_type head;
   assign head = q_mem[rd_ptr_ff];
   assign rsp_tvalid = count_ff != 2'd0;
   assign rsp_tdata = head.rounded;
   assign rsp_tuser = head.status;

   // checks
   `RIM_ASSERT(a_no_overfill, count_ff == 2'd2 |-> !push, "push into full queue")
   `RIM_ASSERT(a_err_zero, rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata == '0, "error not zero")
   `RIM_ASSERT(a_ready_room, req_tready == (count_ff != 2'd2), "ready without room")
   `RIM_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "output valid after reset")
endmodule
`default_nettype wire
